FILE: hdl/camera_ray_direction_top_macros.svh
// Assertion macros used by the checker file of the camera ray direction block.
`ifndef CAMERA_RAY_DIRECTION_TOP_MACROS_SVH
`define CAMERA_RAY_DIRECTION_TOP_MACROS_SVH

// Implication checked in the same cycle, disabled during reset.
`define CRD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) else $error(msg);

// Implication checked in the next cycle, disabled during reset.
`define CRD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hdl/crd_pkg.sv
// Package of the camera ray direction block: widths, register codes and shared types.
package crd_pkg;

    localparam int COORD_FRAC_BITS_DEF = 12;
    localparam int INT_FRAC            = 20;
    localparam int ZOOM_FRAC           = 12;
    localparam int TRIG_FRAC           = 14;
    localparam int NORM_TOP            = 29;

    localparam int VEC_W      = 40;
    localparam int PROD_W     = 57;
    localparam int TOP_W      = 6;
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 60;
    localparam int SUM_W      = 62;
    localparam int ROOT_W     = 31;
    localparam int SQR_REM_W  = 34;
    localparam int QUO_W      = 15;
    localparam int DIV_W      = 46;
    localparam int DIR_W      = 16;
    localparam int UNIT_VALUE = 16384;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_COS_PITCH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_YAW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ROLL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ROLL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM      = 3'd6;

    typedef struct packed {
        logic signed [15:0] cos_pitch;
        logic signed [15:0] sin_pitch;
        logic signed [15:0] cos_yaw;
        logic signed [15:0] sin_yaw;
        logic signed [15:0] cos_roll;
        logic signed [15:0] sin_roll;
        logic        [14:0] zoom;
    } t_cfg;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } t_norm;

endpackage

FILE: hdl/crd_front.sv
// Front part: accepts coordinates, rotates the point and aligns the component magnitudes.
module crd_front #(
    parameter int COORD_FRAC_BITS = crd_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  crd_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [15:0]    i_x,
    input  logic [15:0]    i_y,
    output logic           o_valid,
    input  logic           i_ready,
    output crd_pkg::t_norm o_item
);

    localparam int VW  = crd_pkg::VEC_W;
    localparam int PW  = crd_pkg::PROD_W;
    localparam int TW  = crd_pkg::TOP_W;
    localparam int MW  = crd_pkg::MAG_W;
    localparam int SH  = crd_pkg::INT_FRAC - COORD_FRAC_BITS;
    localparam int ZSH = crd_pkg::INT_FRAC - crd_pkg::ZOOM_FRAC;
    localparam int NST = 11;
    localparam logic signed [PW-1:0] RND_HALF = PW'(1 << (crd_pkg::TRIG_FRAC - 1));
    localparam logic [TW-1:0] TOP_REF = TW'(crd_pkg::NORM_TOP);

    function automatic logic signed [PW-1:0] mul(input logic signed [VW-1:0] a,
                                                 input logic signed [15:0] b);
        logic signed [PW-1:0] ea;
        logic signed [PW-1:0] eb;
        ea = PW'(a);
        eb = PW'(b);
        return ea * eb;
    endfunction

    function automatic logic signed [VW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + RND_HALF) >>> crd_pkg::TRIG_FRAC;
        return t[VW-1:0];
    endfunction

    logic [NST-1:0] r_vld;
    logic           adv;

    logic signed [15:0]    r0_x, r0_y;
    logic signed [VW-1:0]  w_x, w_y, w_z;
    logic signed [VW-1:0]  r1_x;
    logic signed [PW-1:0]  r1_pa, r1_pb, r1_pc, r1_pd;
    logic signed [VW-1:0]  r2_x, r2_y0, r2_z0;
    logic signed [VW-1:0]  r3_z0;
    logic signed [PW-1:0]  r3_pa, r3_pb, r3_pc, r3_pd;
    logic signed [VW-1:0]  r4_z0, r4_x1, r4_y1;
    logic signed [VW-1:0]  r5_y1;
    logic signed [PW-1:0]  r5_pa, r5_pb, r5_pc, r5_pd;
    logic signed [VW-1:0]  r6_v [3];
    logic [2:0][VW-1:0]    r7_mag;
    logic [2:0]            r7_neg;
    logic [2:0][VW-1:0]    r8_mag;
    logic [2:0]            r8_neg;
    logic [VW-1:0]         r8_max;
    logic [2:0][VW-1:0]    r9_mag;
    logic [2:0]            r9_neg;
    logic                  r9_zero;
    logic [TW-1:0]         r9_top;
    logic [TW-1:0]         w_top;
    logic [VW-1:0]         w_max;
    logic [2:0][MW-1:0]    w_norm;
    crd_pkg::t_norm        r10_item;

    assign adv     = !r_vld[NST-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NST-1];
    assign o_item  = r10_item;

    assign w_x = VW'($signed(r0_x)) <<< SH;
    assign w_y = VW'($signed(r0_y)) <<< SH;
    assign w_z = $signed(VW'(i_cfg.zoom)) <<< ZSH;

    always_comb begin
        w_max = r7_mag[0];
        if (r7_mag[1] > w_max) begin
            w_max = r7_mag[1];
        end
        if (r7_mag[2] > w_max) begin
            w_max = r7_mag[2];
        end
    end

    always_comb begin
        w_top = '0;
        for (int k = 0; k < VW; k++) begin
            if (r8_max[k]) begin
                w_top = TW'(k);
            end
        end
    end

    always_comb begin
        logic [VW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            if (r9_top > TOP_REF) begin
                t = r9_mag[i] >> (r9_top - TOP_REF);
            end else begin
                t = r9_mag[i] << (TOP_REF - r9_top);
            end
            w_norm[i] = t[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_x  <= i_x;
            r0_y  <= i_y;
            r1_x  <= w_x;
            r1_pa <= mul(w_y, i_cfg.cos_pitch);
            r1_pb <= mul(w_z, i_cfg.sin_pitch);
            r1_pc <= mul(w_y, i_cfg.sin_pitch);
            r1_pd <= mul(w_z, i_cfg.cos_pitch);
            r2_x  <= r1_x;
            r2_y0 <= rnd(r1_pa - r1_pb);
            r2_z0 <= rnd(r1_pc + r1_pd);
            r3_z0 <= r2_z0;
            r3_pa <= mul(r2_x, i_cfg.cos_roll);
            r3_pb <= mul(r2_y0, i_cfg.sin_roll);
            r3_pc <= mul(r2_x, i_cfg.sin_roll);
            r3_pd <= mul(r2_y0, i_cfg.cos_roll);
            r4_z0 <= r3_z0;
            r4_x1 <= rnd(r3_pa - r3_pb);
            r4_y1 <= rnd(r3_pc + r3_pd);
            r5_y1 <= r4_y1;
            r5_pa <= mul(r4_z0, i_cfg.cos_yaw);
            r5_pb <= mul(r4_x1, i_cfg.sin_yaw);
            r5_pc <= mul(r4_z0, i_cfg.sin_yaw);
            r5_pd <= mul(r4_x1, i_cfg.cos_yaw);
            r6_v[0] <= rnd(r5_pa - r5_pb);
            r6_v[1] <= r5_y1;
            r6_v[2] <= rnd(r5_pc + r5_pd);
            for (int i = 0; i < 3; i++) begin
                r7_neg[i] <= r6_v[i][VW-1];
                r7_mag[i] <= r6_v[i][VW-1] ? VW'(-r6_v[i]) : VW'(r6_v[i]);
            end
            r8_mag  <= r7_mag;
            r8_neg  <= r7_neg;
            r8_max  <= w_max;
            r9_mag  <= r8_mag;
            r9_neg  <= r8_neg;
            r9_zero <= (r8_max == '0);
            r9_top  <= w_top;
            r10_item.mag   <= w_norm;
            r10_item.neg   <= r9_neg;
            r10_item.degen <= r9_zero;
        end
    end

endmodule

FILE: hdl/crd_fifo.sv
// Short queue between the front and back parts.
module crd_fifo #(
    parameter int DEPTH = crd_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  crd_pkg::t_norm i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output crd_pkg::t_norm o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    crd_pkg::t_norm r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt, n_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: hdl/crd_back.sv
// Back part: square root of the squared length and per-component rounded quotients.
module crd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  crd_pkg::t_norm              i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [crd_pkg::DIR_W-1:0]   o_dir_x,
    output logic [crd_pkg::DIR_W-1:0]   o_dir_y,
    output logic [crd_pkg::DIR_W-1:0]   o_dir_z,
    output logic                        o_degen
);

    localparam int MW  = crd_pkg::MAG_W;
    localparam int RW  = crd_pkg::ROOT_W;
    localparam int SW  = crd_pkg::SUM_W;
    localparam int EW  = crd_pkg::SQR_REM_W;
    localparam int QW  = crd_pkg::QUO_W;
    localparam int DW  = crd_pkg::DIV_W;
    localparam int OW  = crd_pkg::DIR_W;
    localparam int NST = 2 + (RW + 1) + (QW + 1) + 1;
    localparam logic [QW-1:0] UNIT = QW'(crd_pkg::UNIT_VALUE);

    typedef struct packed {
        crd_pkg::t_norm item;
        logic [SW-1:0]  s;
        logic [EW-1:0]  rem;
        logic [RW-1:0]  root;
    } t_sq;

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [RW-1:0]      l;
        logic [2:0]         neg;
        logic               degen;
    } t_dv;

    logic [NST-1:0]               r_vld;
    logic                         adv;
    crd_pkg::t_norm               r_b0;
    crd_pkg::t_norm               r_b1;
    logic [2:0][crd_pkg::SQ_W-1:0] r_b1_sq;
    t_sq                          r_sq [RW+1];
    t_dv                          r_dv [QW+1];
    logic [OW-1:0]                r_dir [3];
    logic                         r_degen;

    assign adv     = !r_vld[NST-1] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[NST-1];
    assign o_dir_x = r_dir[0];
    assign o_dir_y = r_dir[1];
    assign o_dir_z = r_dir[2];
    assign o_degen = r_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b0 <= i_item;
            r_b1 <= r_b0;
            for (int i = 0; i < 3; i++) begin
                r_b1_sq[i] <= r_b0.mag[i] * r_b0.mag[i];
            end
            r_sq[0].item <= r_b1;
            r_sq[0].s    <= SW'(r_b1_sq[0]) + SW'(r_b1_sq[1]) + SW'(r_b1_sq[2]);
            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
        end
    end

    for (genvar g = 1; g <= RW; g++) begin : g_sqrt
        logic [EW-1:0] w_rem;
        logic [EW-1:0] w_trial;
        assign w_rem   = {r_sq[g-1].rem[EW-3:0], r_sq[g-1].s[SW-1 -: 2]};
        assign w_trial = {1'b0, r_sq[g-1].root, 2'b01};
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq[g].item <= r_sq[g-1].item;
                r_sq[g].s    <= r_sq[g-1].s << 2;
                if (w_rem >= w_trial) begin
                    r_sq[g].rem  <= w_rem - w_trial;
                    r_sq[g].root <= {r_sq[g-1].root[RW-2:0], 1'b1};
                end else begin
                    r_sq[g].rem  <= w_rem;
                    r_sq[g].root <= {r_sq[g-1].root[RW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_dv[0].rem[i] <= (DW'(r_sq[RW].item.mag[i]) << crd_pkg::TRIG_FRAC)
                                  + DW'(r_sq[RW].root >> 1);
            end
            r_dv[0].q     <= '0;
            r_dv[0].l     <= r_sq[RW].root;
            r_dv[0].neg   <= r_sq[RW].item.neg;
            r_dv[0].degen <= r_sq[RW].item.degen;
        end
    end

    for (genvar h = 1; h <= QW; h++) begin : g_div
        logic [DW-1:0] w_trial;
        assign w_trial = DW'(r_dv[h-1].l) << (QW - h);
        always_ff @(posedge i_clk) begin
            logic [QW-1:0] tq;
            if (adv) begin
                r_dv[h].l     <= r_dv[h-1].l;
                r_dv[h].neg   <= r_dv[h-1].neg;
                r_dv[h].degen <= r_dv[h-1].degen;
                for (int i = 0; i < 3; i++) begin
                    tq = r_dv[h-1].q[i];
                    if (r_dv[h-1].rem[i] >= w_trial) begin
                        r_dv[h].rem[i] <= r_dv[h-1].rem[i] - w_trial;
                        tq[QW - h]     = 1'b1;
                    end else begin
                        r_dv[h].rem[i] <= r_dv[h-1].rem[i];
                    end
                    r_dv[h].q[i] <= tq;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [QW-1:0] q;
        logic [OW-1:0] d;
        if (adv) begin
            r_degen <= r_dv[QW].degen;
            for (int i = 0; i < 3; i++) begin
                q = (r_dv[QW].q[i] > UNIT) ? UNIT : r_dv[QW].q[i];
                d = OW'(q);
                if (r_dv[QW].degen) begin
                    r_dir[i] <= '0;
                end else if (r_dv[QW].neg[i]) begin
                    r_dir[i] <= -d;
                end else begin
                    r_dir[i] <= d;
                end
            end
        end
    end

endmodule

FILE: hdl/camera_ray_direction_top.sv
// Top level of the camera ray direction block: registers, front, queue and back.
//
// Takes one screen coordinate beat per cycle and returns one unit ray direction beat per
// cycle in steady state while the output is not stalled. An accepted input beat passes
// through the front rotation pipeline, the four-entry queue and the back pipeline, whose
// depth is set by the 31-stage square root and the 15-stage dividers.
// Registers 0 to 5 hold cosines and sines in Q2.14, register 6 holds the zoom in Q3.12;
// write them only while no beat is in flight. A zero-length rotated vector gives a zero
// direction with tuser set.
module camera_ray_direction_top #(
    parameter int COORD_FRAC_BITS = crd_pkg::COORD_FRAC_BITS_DEF,
    parameter int FIFO_DEPTH      = crd_pkg::FIFO_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [crd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [crd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,  // x_coord, y_coord
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [47:0]                   o_m_axis_tdata,  // dir_x, dir_y, dir_z
    output logic                          o_m_axis_tuser   // degenerate
);

    crd_pkg::t_cfg  r_cfg;
    crd_pkg::t_norm front_item, fifo_item;
    logic           front_valid, fifo_in_ready, fifo_valid, back_ready;
    logic [crd_pkg::DIR_W-1:0] dir_x, dir_y, dir_z;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_pitch <= 16'sd16384;
            r_cfg.sin_pitch <= 16'sd0;
            r_cfg.cos_yaw   <= 16'sd0;
            r_cfg.sin_yaw   <= 16'sd16384;
            r_cfg.cos_roll  <= 16'sd16384;
            r_cfg.sin_roll  <= 16'sd0;
            r_cfg.zoom      <= 15'd8192;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                crd_pkg::CFG_COS_PITCH: r_cfg.cos_pitch <= i_cfg_data;
                crd_pkg::CFG_SIN_PITCH: r_cfg.sin_pitch <= i_cfg_data;
                crd_pkg::CFG_COS_YAW:   r_cfg.cos_yaw   <= i_cfg_data;
                crd_pkg::CFG_SIN_YAW:   r_cfg.sin_yaw   <= i_cfg_data;
                crd_pkg::CFG_COS_ROLL:  r_cfg.cos_roll  <= i_cfg_data;
                crd_pkg::CFG_SIN_ROLL:  r_cfg.sin_roll  <= i_cfg_data;
                crd_pkg::CFG_ZOOM:      r_cfg.zoom      <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    crd_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_x     (i_s_axis_tdata[15:0]),
        .i_y     (i_s_axis_tdata[31:16]),
        .o_valid (front_valid),
        .i_ready (fifo_in_ready),
        .o_item  (front_item)
    );

    crd_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (fifo_in_ready),
        .i_item  (front_item),
        .o_valid (fifo_valid),
        .i_ready (back_ready),
        .o_item  (fifo_item)
    );

    crd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fifo_valid),
        .o_ready (back_ready),
        .i_item  (fifo_item),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_dir_x (dir_x),
        .o_dir_y (dir_y),
        .o_dir_z (dir_z),
        .o_degen (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {dir_z, dir_y, dir_x};

endmodule

FILE: hdl/crd_checker.sv
// Port-level assertions for the camera ray direction block and their bind.
`include "camera_ray_direction_top_macros.svh"

module crd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    `CRD_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output beat dropped while stalled")
    `CRD_ASSERT_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "output beat changed while stalled")
    `CRD_ASSERT_NOW(a_degen_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == 48'd0, "degenerate beat carries a nonzero direction")
    `CRD_ASSERT_NOW(a_x_range, o_m_axis_tvalid, $signed(o_m_axis_tdata[15:0]) <= 16'sd16384 && $signed(o_m_axis_tdata[15:0]) >= -16'sd16384, "dir_x outside the unit range")

endmodule

bind camera_ray_direction_top crd_checker u_crd_checker (.*);

FILE: bench/tb_top.sv
// Testbench of the camera ray direction block: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

    typedef struct {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic               degen;
    } t_dir;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [crd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [crd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    camera_ray_direction_top dut (.*);

    always #5 i_clk = ~i_clk;

    logic signed [15:0] cp, sp, cy, sy, cr, sr;
    logic [14:0] zm;
    logic [31:0] coord_queue[$];
    t_dir        dir_queue[$];
    int          errors = 0;
    int          send_idle = 7;
    int          recv_idle = 84;
    bit          hold_off = 1'b0;
    bit          cfg_busy = 1'b0;

    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic t_dir ray_direction(input logic [31:0] coords);
        logic signed [63:0] x, y, z, y0, z0, x1, y1;
        logic signed [63:0] v[3];
        logic [63:0] mag[3], m, s, l, q;
        int top;
        t_dir d;
        x = 64'($signed(coords[15:0])) <<< (crd_pkg::INT_FRAC - crd_pkg::COORD_FRAC_BITS_DEF);
        y = 64'($signed(coords[31:16])) <<< (crd_pkg::INT_FRAC - crd_pkg::COORD_FRAC_BITS_DEF);
        z = 64'(zm) << (crd_pkg::INT_FRAC - crd_pkg::ZOOM_FRAC);
        y0 = rnd14(y * cp - z * sp);
        z0 = rnd14(y * sp + z * cp);
        x1 = rnd14(x * cr - y0 * sr);
        y1 = rnd14(x * sr + y0 * cr);
        v[0] = rnd14(z0 * cy - x1 * sy);
        v[1] = y1;
        v[2] = rnd14(z0 * sy + x1 * cy);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > m) m = mag[i];
        end
        d = '{0, 0, 0, 1'b1};
        if (m == 0) return d;
        top = 63;
        while (m[top] == 1'b0) top--;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            if (top > crd_pkg::NORM_TOP) mag[i] = mag[i] >> (top - crd_pkg::NORM_TOP);
            else mag[i] = mag[i] << (crd_pkg::NORM_TOP - top);
            s = s + mag[i] * mag[i];
        end
        l = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << crd_pkg::TRIG_FRAC) + (l >> 1)) / l;
            if (q > crd_pkg::UNIT_VALUE) q = crd_pkg::UNIT_VALUE;
            q = v[i] < 0 ? -q : q;
            if (i == 0) d.dx = q[15:0];
            else if (i == 1) d.dy = q[15:0];
            else d.dz = q[15:0];
        end
        d.degen = 1'b0;
        return d;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // Driver: predict each beat when it is accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                dir_queue.push_back(ray_direction(i_s_axis_tdata));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (!cfg_busy && coord_queue.size() > 0 &&
                        $urandom_range(99) >= send_idle) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= coord_queue.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_dir want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (dir_queue.size() == 0) begin
                    report("unexpected beat", o_m_axis_tdata[15:0], 16'h0);
                end else begin
                    want = dir_queue.pop_front();
                    if (o_m_axis_tdata[15:0] !== want.dx) report("dir_x", o_m_axis_tdata[15:0], want.dx);
                    if (o_m_axis_tdata[31:16] !== want.dy) report("dir_y", o_m_axis_tdata[31:16], want.dy);
                    if (o_m_axis_tdata[47:32] !== want.dz) report("dir_z", o_m_axis_tdata[47:32], want.dz);
                    if (o_m_axis_tuser !== want.degen)
                        report("degenerate", 16'(o_m_axis_tuser), 16'(want.degen));
                end
            end
            if (hold_off) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= $urandom_range(99) >= recv_idle;
            end
        end
    end

    task automatic drain();
        while (coord_queue.size() > 0 || i_s_axis_tvalid || dir_queue.size() > 0)
            @(negedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [crd_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            crd_pkg::CFG_COS_PITCH: cp = val;
            crd_pkg::CFG_SIN_PITCH: sp = val;
            crd_pkg::CFG_COS_YAW:   cy = val;
            crd_pkg::CFG_SIN_YAW:   sy = val;
            crd_pkg::CFG_COS_ROLL:  cr = val;
            crd_pkg::CFG_SIN_ROLL:  sr = val;
            crd_pkg::CFG_ZOOM:      zm = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_angles(input logic [15:0] a, b, c, d, e, f, input logic [15:0] z);
        drain();
        cfg_busy = 1'b1;
        write_reg(crd_pkg::CFG_COS_PITCH, a);
        write_reg(crd_pkg::CFG_SIN_PITCH, b);
        write_reg(crd_pkg::CFG_COS_YAW, c);
        write_reg(crd_pkg::CFG_SIN_YAW, d);
        write_reg(crd_pkg::CFG_COS_ROLL, e);
        write_reg(crd_pkg::CFG_SIN_ROLL, f);
        write_reg(crd_pkg::CFG_ZOOM, z);
        i_cfg_valid <= 1'b0;
        cfg_busy = 1'b0;
    endtask

    function automatic logic [15:0] trig();
        case ($urandom_range(5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h0;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic [15:0] coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(3)) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++) coord_queue.push_back({coord(), coord()});
    endtask

    initial begin
        cp = 16'sd16384; sp = 16'sd0; cy = 16'sd0; sy = 16'sd16384;
        cr = 16'sd16384; sr = 16'sd0; zm = 15'd8192;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset settings, then corners of the screen and the origin.
        coord_queue = '{32'h0, 32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000,
                        32'h8000_7FFF, 32'h0001_FFFF, 32'h1000_F000};
        drain();
        // Zero zoom: the origin rotates to a zero vector.
        set_angles(16'd16384, 16'd0, 16'd16384, 16'd0, 16'd16384, 16'd0, 16'd0);
        coord_queue = '{32'h0, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF};
        drain();
        set_angles(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        coord_queue = '{32'h0, 32'h7FFF_7FFF, 32'h8000_8000, 32'hAAAA_5555, 32'h5555_AAAA};
        drain();
        // The receiver stalls for a long stretch so that the block fills up.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        random_items(150);
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle = 84; recv_idle = 7; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            for (int k = 0; k < 4; k++) begin
                set_angles(trig(), trig(), trig(), trig(), trig(), trig(),
                           $urandom_range(3) == 0 ? 16'($urandom_range(32767)) :
                                                    16'($urandom_range(3) << 12));
                random_items(120);
            end
        end
        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
